// ----- rtl/core/disk_parameter_block_skew_table_defines.svh -----
// Assertion macros for the disk parameter block and skew table core.
// No dependencies; included by the modules that carry assertions.
`ifndef DISK_PARAMETER_BLOCK_SKEW_TABLE_DEFINES_SVH
`define DISK_PARAMETER_BLOCK_SKEW_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked only outside reset.
`define DPBST_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define DPBST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DPBST_ASSERT(lbl, clk, rst_n, prop, msg)
`define DPBST_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- rtl/core/dpbst_pkg.sv -----
// Shared types and constants for the disk parameter block and skew table core.
// No dependencies.
package dpbst_pkg;

	localparam int MAX_SECTORS_DEF = 32;
	localparam int DIR_BITMAP_BITS = 16;
	localparam int SEC_W           = 6;
	localparam int OFS_W           = SEC_W + 1;
	localparam int ALU_W           = 17;
	localparam int ONES_W          = $clog2(DIR_BITMAP_BITS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_DIV,
		ST_REC,
		ST_WALK
	} st_t;

	typedef struct packed {
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [ALU_W-1:0] diff;
		logic             ge;
	} alu_rsp_t;

	typedef struct packed {
		logic [SEC_W-1:0] sectors;
		logic [2:0]       shift;
		logic [6:0]       mask;
		logic [3:0]       ext;
		logic [15:0]      max_block;
		logic [15:0]      max_dir;
		logic [13:0]      check_size;
		logic [13:0]      alloc_bytes;
		logic [9:0]       per_blk;
	} rec_t;

endpackage

// ----- rtl/core/dpbst_alu.sv -----
// Shared subtract and compare unit of the parameter block sequencer.
// Depends on dpbst_pkg.
module dpbst_alu import dpbst_pkg::*; (
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic [ALU_W:0] full;

	// The carry out of a + ~b + 1 is set exactly when a >= b.
	assign full     = {1'b0, req.a} + {1'b0, ~req.b} + {{ALU_W{1'b0}}, 1'b1};
	assign rsp.diff = full[ALU_W-1:0];
	assign rsp.ge   = full[ALU_W];

endmodule

// ----- rtl/core/dpbst_record.sv -----
// Decode of the fixed fields of the disk parameter record.
// Depends on dpbst_pkg.
module dpbst_record import dpbst_pkg::*; #(
	parameter int MAX_SECTORS = MAX_SECTORS_DEF
) (
	input  logic [7:0]  first_sector,
	input  logic [7:0]  last_sector,
	input  logic [14:0] block_size,
	input  logic [15:0] disk_blocks,
	input  logic [15:0] dir_entries,
	input  logic [15:0] checked_entries,
	input  logic        use_fixed_extent,
	input  logic [3:0]  fixed_extent_mask,
	output rec_t        rec
);

	logic [8:0]  span;
	logic [7:0]  recs;
	logic [4:0]  kblk;
	logic [2:0]  klog;
	logic [3:0]  ext_raw;
	logic [16:0] av_sum;

	always_comb begin
		if (last_sector >= first_sector) begin
			span = {1'b0, last_sector} - {1'b0, first_sector} + 9'd1;
		end else begin
			span = 9'd1;
		end
		if (span > 9'(MAX_SECTORS)) begin
			rec.sectors = SEC_W'(MAX_SECTORS);
		end else begin
			rec.sectors = span[SEC_W-1:0];
		end
	end

	// Floor of log2 by priority encode; values of zero and one both give zero.
	assign recs = block_size[14:7];
	always_comb begin
		rec.shift = 3'd0;
		for (int i = 1; i < 8; i++) begin
			if (recs[i]) begin
				rec.shift = 3'(i);
			end
		end
	end
	assign rec.mask = 7'((8'd1 << rec.shift) - 8'd1);

	assign kblk = block_size[14:10];
	always_comb begin
		klog = 3'd0;
		for (int i = 1; i < 5; i++) begin
			if (kblk[i]) begin
				klog = 3'(i);
			end
		end
		ext_raw = 4'((5'd1 << klog) - 5'd1);
		if (disk_blocks > 16'd256) begin
			ext_raw = ext_raw >> 1;
		end
		rec.ext = use_fixed_extent ? fixed_extent_mask : ext_raw;
	end

	assign av_sum          = {1'b0, disk_blocks} + 17'd7;
	assign rec.max_block   = disk_blocks - 16'd1;
	assign rec.max_dir     = dir_entries - 16'd1;
	assign rec.check_size  = checked_entries[15:2];
	assign rec.alloc_bytes = av_sum[16:3];
	assign rec.per_blk     = block_size[14:5];

endmodule

// ----- rtl/core/disk_parameter_block_skew_table.sv -----
// Top level of the disk parameter block and sector skew table core.
// Depends on dpbst_pkg, dpbst_alu, dpbst_record and the defines header.
//
// Channel   Direction  Handshake            Contents
// request   in         start, busy          one disk definition
// result    out        strobe (one cycle)   parameter record, then skew entries
//
// A request is taken when start is high and busy is low. The sequencer reduces
// the skew below the sector count, counts directory blocks (ones at most
// DIR_BITMAP_BITS), shows the record and, when skew is nonzero, walks one
// table entry per sector. Both loops run on the single shared subtractor, which
// also folds the table offset back below the sector count during the walk.
// Reset is asynchronous and returns the sequencer to idle. The receiver cannot
// stall: each result is shown for exactly one cycle under strobe.
`include "disk_parameter_block_skew_table_defines.svh"
module disk_parameter_block_skew_table import dpbst_pkg::*; #(
	parameter int MAX_SECTORS = MAX_SECTORS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  first_sector,
	input  logic [7:0]  last_sector,
	input  logic [5:0]  skew,
	input  logic [14:0] block_size,
	input  logic [15:0] disk_blocks,
	input  logic [15:0] dir_entries,
	input  logic [15:0] checked_entries,
	input  logic        use_fixed_extent,
	input  logic [3:0]  fixed_extent_mask,
	output logic        strobe,
	output logic        kind,
	output logic        last,
	output logic [5:0]  sectors_per_track,
	output logic [2:0]  block_shift,
	output logic [6:0]  block_mask,
	output logic [3:0]  extent_mask,
	output logic [15:0] max_block,
	output logic [15:0] max_dir,
	output logic [15:0] dir_alloc_bitmap,
	output logic [13:0] check_size,
	output logic [13:0] alloc_vector_bytes,
	output logic [7:0]  translated_sector
);

	// Latched request fields.
	logic [7:0]  first_q;
	logic [7:0]  last_q;
	logic [5:0]  skew_q;
	logic [14:0] bsize_q;
	logic [15:0] dks_q;
	logic [15:0] dir_q;
	logic [15:0] cks_q;
	logic        usefix_q;
	logic [3:0]  fixmask_q;

	st_t state_q, state_d;

	// Working registers of the two subtract loops and the table walk.
	logic [ALU_W-1:0]  rem_q;
	logic [SEC_W-1:0]  step_q;
	logic [ONES_W-1:0] ones_q;
	logic [SEC_W-1:0]  next_offset_q;
	logic [SEC_W-1:0]  cycle_base_q;
	logic [SEC_W-1:0]  entries_q;

	rec_t     rec;
	alu_req_t alu_req;
	alu_rsp_t alu_rsp;

	logic             accept;
	logic             div_done;
	logic             walk_last;
	logic [OFS_W-1:0] ofs_sum;
	logic [SEC_W-1:0] ofs_next;
	logic [SEC_W-1:0] base_next;

	dpbst_record #(
		.MAX_SECTORS(MAX_SECTORS)
	) u_record (
		.first_sector     (first_q),
		.last_sector      (last_q),
		.block_size       (bsize_q),
		.disk_blocks      (dks_q),
		.dir_entries      (dir_q),
		.checked_entries  (cks_q),
		.use_fixed_extent (usefix_q),
		.fixed_extent_mask(fixmask_q),
		.rec              (rec)
	);

	dpbst_alu u_alu (
		.req(alu_req),
		.rsp(alu_rsp)
	);

	assign accept    = start && !busy;
	assign div_done  = (rem_q == '0) || (ones_q == ONES_W'(DIR_BITMAP_BITS));
	assign walk_last = (entries_q == rec.sectors - SEC_W'(1));
	assign ofs_sum   = {1'b0, next_offset_q} + {1'b0, step_q};
	assign base_next = cycle_base_q + SEC_W'(1);

	// The subtractor serves the skew reduction, the directory block count and
	// the wrap of the table offset; the sequencer picks its operands.
	always_comb begin
		case (state_q)
			ST_DIV: begin
				alu_req.a = rem_q;
				alu_req.b = ALU_W'(rec.per_blk);
			end
			ST_WALK: begin
				alu_req.a = ALU_W'(ofs_sum);
				alu_req.b = ALU_W'(rec.sectors);
			end
			default: begin
				alu_req.a = rem_q;
				alu_req.b = ALU_W'(rec.sectors);
			end
		endcase
	end

	// Offset after one skew step, folded below the sector count.
	assign ofs_next = alu_rsp.ge ? alu_rsp.diff[SEC_W-1:0] : ofs_sum[SEC_W-1:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_MOD;
				end
			end
			ST_MOD: begin
				if (!alu_rsp.ge) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_REC;
				end
			end
			ST_REC: begin
				state_d = (skew_q == '0) ? ST_IDLE : ST_WALK;
			end
			ST_WALK: begin
				if (walk_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			first_q   <= first_sector;
			last_q    <= last_sector;
			skew_q    <= skew;
			bsize_q   <= block_size;
			dks_q     <= disk_blocks;
			dir_q     <= dir_entries;
			cks_q     <= checked_entries;
			usefix_q  <= use_fixed_extent;
			fixmask_q <= fixed_extent_mask;
			rem_q     <= ALU_W'(skew);
		end else begin
			case (state_q)
				ST_MOD: begin
					if (alu_rsp.ge) begin
						rem_q <= alu_rsp.diff;
					end else begin
						step_q <= rem_q[SEC_W-1:0];
						rem_q  <= ALU_W'(dir_q);
						ones_q <= '0;
					end
				end
				ST_DIV: begin
					// Counting subtractions until the remainder is used up gives
					// the rounded-up quotient, capped at the bitmap width.
					if (!div_done) begin
						rem_q  <= alu_rsp.ge ? alu_rsp.diff : '0;
						ones_q <= ones_q + ONES_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Table walk registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_offset_q <= '0;
			cycle_base_q  <= '0;
			entries_q     <= '0;
		end else begin
			case (state_q)
				ST_REC: begin
					next_offset_q <= '0;
					cycle_base_q  <= '0;
					entries_q     <= '0;
				end
				ST_WALK: begin
					// The offset orbit closes when it comes back to the base of
					// the current cycle; the next cycle then starts one higher.
					if (ofs_next == cycle_base_q) begin
						cycle_base_q  <= base_next;
						next_offset_q <= base_next;
					end else begin
						next_offset_q <= ofs_next;
					end
					entries_q <= entries_q + SEC_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// Result outputs, decoded from the sequencer state.
	always_comb begin
		busy               = (state_q != ST_IDLE);
		strobe             = 1'b0;
		kind               = 1'b0;
		last               = 1'b0;
		sectors_per_track  = '0;
		block_shift        = '0;
		block_mask         = '0;
		extent_mask        = '0;
		max_block          = '0;
		max_dir            = '0;
		dir_alloc_bitmap   = '0;
		check_size         = '0;
		alloc_vector_bytes = '0;
		translated_sector  = '0;
		case (state_q)
			ST_REC: begin
				strobe             = 1'b1;
				last               = (skew_q == '0);
				sectors_per_track  = rec.sectors;
				block_shift        = rec.shift;
				block_mask         = rec.mask;
				extent_mask        = rec.ext;
				max_block          = rec.max_block;
				max_dir            = rec.max_dir;
				dir_alloc_bitmap   = ~({DIR_BITMAP_BITS{1'b1}} >> ones_q);
				check_size         = rec.check_size;
				alloc_vector_bytes = rec.alloc_bytes;
			end
			ST_WALK: begin
				strobe            = 1'b1;
				kind              = 1'b1;
				last              = walk_last;
				translated_sector = first_q + 8'(next_offset_q);
			end
			default: begin
			end
		endcase
	end

	`DPBST_ASSERT(a_accept_no_result, clk, arst_n, accept |=> busy && !strobe, "result right after request")
	`DPBST_ASSERT(a_last_frees, clk, arst_n, strobe && last |=> !busy, "busy after final result")
	`DPBST_ASSERT(a_table_follows, clk, arst_n, strobe && !kind && !last |=> strobe && kind, "table did not follow record")
	`DPBST_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !strobe && !busy, "activity during reset")

endmodule
